>>> rtl/sbrd_pkg.sv
// Shared types and constants for the bit-packed record decoder.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package sbrd_pkg;

   // Record kinds carried on the first byte of a record
   localparam logic [1:0] CMD_RECT   = 2'd0;
   localparam logic [1:0] CMD_MATRIX = 2'd1;
   localparam logic [1:0] CMD_CXFORM = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   // Widths of the width fields and of the flag fields
   localparam logic [4:0] WIDTH_FIELD_BITS = 5'd5;
   localparam logic [4:0] CX_WIDTH_BITS    = 5'd4;
   localparam logic [4:0] FLAG_BITS        = 5'd1;

   // 1.0 in 16.16 form, given for an absent scale pair
   localparam logic [31:0] SCALE_ONE = 32'h0001_0000;

   // Output field codes
   typedef enum logic [4:0] {
      FC_RECT_XMIN = 5'd0,
      FC_RECT_XMAX = 5'd1,
      FC_RECT_YMIN = 5'd2,
      FC_RECT_YMAX = 5'd3,
      FC_SCALE_X   = 5'd4,
      FC_SCALE_Y   = 5'd5,
      FC_ROT0      = 5'd6,
      FC_ROT1      = 5'd7,
      FC_TRANS_X   = 5'd8,
      FC_TRANS_Y   = 5'd9,
      FC_MULT_R    = 5'd10,
      FC_MULT_G    = 5'd11,
      FC_MULT_B    = 5'd12,
      FC_MULT_A    = 5'd13,
      FC_ADD_R     = 5'd14,
      FC_ADD_G     = 5'd15,
      FC_ADD_B     = 5'd16,
      FC_ADD_A     = 5'd17
   } field_code_type;

   // Position within a record; consecutive codes follow record order
   typedef enum logic [4:0] {
      ST_IDLE      = 5'd0,
      ST_RECT_W    = 5'd1,
      ST_RECT_V0   = 5'd2,
      ST_RECT_V1   = 5'd3,
      ST_RECT_V2   = 5'd4,
      ST_RECT_V3   = 5'd5,
      ST_HAS_SCALE = 5'd6,
      ST_SCALE_W   = 5'd7,
      ST_SCALE_V0  = 5'd8,
      ST_SCALE_V1  = 5'd9,
      ST_HAS_ROT   = 5'd10,
      ST_ROT_W     = 5'd11,
      ST_ROT_V0    = 5'd12,
      ST_ROT_V1    = 5'd13,
      ST_TRANS_W   = 5'd14,
      ST_TRANS_V0  = 5'd15,
      ST_TRANS_V1  = 5'd16,
      ST_ADD_FLAG  = 5'd17,
      ST_MULT_FLAG = 5'd18,
      ST_CX_W      = 5'd19,
      ST_MULT_R    = 5'd20,
      ST_MULT_G    = 5'd21,
      ST_MULT_B    = 5'd22,
      ST_MULT_A    = 5'd23,
      ST_ADD_R     = 5'd24,
      ST_ADD_G     = 5'd25,
      ST_ADD_B     = 5'd26,
      ST_ADD_A     = 5'd27
   } step_type;

   // Controller states
   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_RUN  = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [1:0] command;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]         field_code;
      logic signed [31:0] value;
      logic               record_last;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic run;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic drop;
      logic done;
      logic out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

>>> rtl/swf_bit_record_decoder_unit.sv
// Top level of the bit-packed record decoder: controller plus datapath.
// Depends on sbrd_pkg, sbrd_ctrl and sbrd_datapath.
//
// Usage:
//   req_* carries one stream byte per transfer, consumed MSB first, with the
//   record kind in req_payload.command; the kind is looked at only on the
//   first byte of a record (kind 3 there drops the byte). rsp_* carries one
//   decoded field per transfer: code, sign-extended value, last-of-record.
//   A byte is loaded first; then the datapath runs one field step per cycle
//   while the output register is free, for each step the byte completes or
//   extends, width and flag steps and zero-width or absent fields included
//   (a colour transform with both flags clear and width zero runs 11 steps
//   in its first byte). A result appears in the output register the cycle
//   after the step that finishes it.
//   req_stall is high from the cycle after a load until the byte is used up.
//   While rsp_stall holds a waiting result, the datapath pauses on every
//   cycle, whether or not its next step emits a field.
//   Synchronous reset clears the decoder to await a record start and empties
//   the output register.
`default_nettype none

module swf_bit_record_decoder_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sbrd_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sbrd_pkg::rsp_payload_type rsp_payload
);
   import sbrd_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   sbrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sbrd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

>>> rtl/sbrd_ctrl.sv
// Controller for the record decoder: sequences byte load and bit processing.
// Depends on sbrd_pkg; drives the datapath through ctrl_cmd_type.
`default_nettype none

module sbrd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sbrd_pkg::ctrl_status_type status,
   output sbrd_pkg::ctrl_cmd_type    cmd
);
   import sbrd_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid && !status.drop) begin
               state_in = CS_RUN;
            end
         end
         CS_RUN: begin
            if (status.out_free && status.done) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_stall = 1'b1;
      cmd.load  = 1'b0;
      cmd.run   = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         CS_RUN: begin
            cmd.run = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/sbrd_datapath.sv
// Datapath for the record decoder: bit buffer, field accumulator, record
// position and the result register. Depends on sbrd_pkg.
`default_nettype none

module sbrd_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  sbrd_pkg::req_payload_type req_payload,
   input  logic                      rsp_stall,
   input  sbrd_pkg::ctrl_cmd_type    cmd,
   output sbrd_pkg::ctrl_status_type status,
   output logic                      rsp_valid,
   output sbrd_pkg::rsp_payload_type rsp_payload
);
   import sbrd_pkg::*;

   // Bits a step takes from the stream
   function automatic logic [4:0] step_need(input step_type s, input logic [4:0] w);
      logic [4:0] n;
      case (s)
         ST_RECT_W, ST_SCALE_W, ST_ROT_W, ST_TRANS_W: n = WIDTH_FIELD_BITS;
         ST_CX_W:                                     n = CX_WIDTH_BITS;
         ST_HAS_SCALE, ST_HAS_ROT,
         ST_ADD_FLAG, ST_MULT_FLAG:                   n = FLAG_BITS;
         ST_IDLE:                                     n = 5'd0;
         default:                                     n = w;
      endcase
      return n;
   endfunction

   logic [7:0]      buf_ff, buf_in;
   logic [3:0]      bleft_ff, bleft_in;
   logic [31:0]     acc_ff, acc_in;
   logic [4:0]      need_ff, need_in;
   logic [4:0]      width_ff, width_in;
   logic [1:0]      pres_ff, pres_in;
   logic            fill_ff, fill_in;
   step_type        step_ff, step_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [3:0]      take;
   logic [31:0]     acc_cons;
   logic [7:0]      buf_cons;
   logic [3:0]      bleft_cons;
   logic [4:0]      need_cons;
   logic            field_done;
   logic [4:0]      wm1;
   logic [31:0]     sext_val;
   step_type        start_step;

   step_type        nstep;
   logic [4:0]      nwidth;
   logic [1:0]      npres;
   logic            nfill;
   logic [4:0]      nneed;
   logic            emit;
   logic [4:0]      ecode;
   logic [31:0]     eval;
   logic            elast;

   // Take as many bits as the field needs and the byte still holds
   always_comb begin
      if (need_ff < {1'b0, bleft_ff}) begin
         take = need_ff[3:0];
      end else begin
         take = bleft_ff;
      end
      acc_cons   = (acc_ff << take) | ({24'd0, buf_ff} >> (4'd8 - take));
      buf_cons   = buf_ff << take;
      bleft_cons = bleft_ff - take;
      need_cons  = need_ff - {1'b0, take};
      field_done = (need_cons == 5'd0);
   end

   // Sign-extend a completed value from the current width
   always_comb begin
      wm1      = width_ff - 5'd1;
      sext_val = acc_cons;
      if ((width_ff != 5'd0) && acc_cons[wm1]) begin
         sext_val = acc_cons | (32'hFFFF_FFFF << width_ff);
      end
   end

   // Act on a completed field; absent terms walk the value steps in fill mode
   always_comb begin
      nstep  = step_type'(step_ff + 5'd1);
      nwidth = width_ff;
      npres  = pres_ff;
      nfill  = fill_ff;
      emit   = 1'b0;
      ecode  = FC_RECT_XMIN;
      eval   = fill_ff ? 32'd0 : sext_val;
      elast  = 1'b0;
      case (step_ff)
         ST_RECT_W, ST_SCALE_W, ST_ROT_W, ST_TRANS_W: begin
            nwidth = acc_cons[4:0];
         end
         ST_RECT_V0: begin
            emit  = 1'b1;
            ecode = FC_RECT_XMIN;
         end
         ST_RECT_V1: begin
            emit  = 1'b1;
            ecode = FC_RECT_XMAX;
         end
         ST_RECT_V2: begin
            emit  = 1'b1;
            ecode = FC_RECT_YMIN;
         end
         ST_RECT_V3: begin
            emit  = 1'b1;
            ecode = FC_RECT_YMAX;
            elast = 1'b1;
            nstep = ST_IDLE;
         end
         ST_HAS_SCALE: begin
            if (!acc_cons[0]) begin
               nstep = ST_SCALE_V0;
               nfill = 1'b1;
            end
         end
         ST_SCALE_V0: begin
            emit  = 1'b1;
            ecode = FC_SCALE_X;
            eval  = fill_ff ? SCALE_ONE : sext_val;
         end
         ST_SCALE_V1: begin
            emit  = 1'b1;
            ecode = FC_SCALE_Y;
            eval  = fill_ff ? SCALE_ONE : sext_val;
            nfill = 1'b0;
         end
         ST_HAS_ROT: begin
            if (!acc_cons[0]) begin
               nstep = ST_ROT_V0;
               nfill = 1'b1;
            end
         end
         ST_ROT_V0: begin
            emit  = 1'b1;
            ecode = FC_ROT0;
         end
         ST_ROT_V1: begin
            emit  = 1'b1;
            ecode = FC_ROT1;
            nfill = 1'b0;
         end
         ST_TRANS_V0: begin
            emit  = 1'b1;
            ecode = FC_TRANS_X;
         end
         ST_TRANS_V1: begin
            emit  = 1'b1;
            ecode = FC_TRANS_Y;
            elast = 1'b1;
            nstep = ST_IDLE;
         end
         ST_ADD_FLAG: begin
            npres[1] = acc_cons[0];
         end
         ST_MULT_FLAG: begin
            npres[0] = acc_cons[0];
         end
         ST_CX_W: begin
            nwidth = {1'b0, acc_cons[3:0]};
            nfill  = !pres_ff[0];
         end
         ST_MULT_R: begin
            emit  = 1'b1;
            ecode = FC_MULT_R;
         end
         ST_MULT_G: begin
            emit  = 1'b1;
            ecode = FC_MULT_G;
         end
         ST_MULT_B: begin
            emit  = 1'b1;
            ecode = FC_MULT_B;
         end
         ST_MULT_A: begin
            emit  = 1'b1;
            ecode = FC_MULT_A;
            nfill = !pres_ff[1];
         end
         ST_ADD_R: begin
            emit  = 1'b1;
            ecode = FC_ADD_R;
         end
         ST_ADD_G: begin
            emit  = 1'b1;
            ecode = FC_ADD_G;
         end
         ST_ADD_B: begin
            emit  = 1'b1;
            ecode = FC_ADD_B;
         end
         ST_ADD_A: begin
            emit  = 1'b1;
            ecode = FC_ADD_A;
            elast = 1'b1;
            nstep = ST_IDLE;
            nfill = 1'b0;
         end
         default: begin
            nstep = ST_IDLE;
            nfill = 1'b0;
         end
      endcase
      if (nstep == ST_IDLE || nfill) begin
         nneed = 5'd0;
      end else begin
         nneed = step_need(nstep, nwidth);
      end
   end

   // First step of a new record
   always_comb begin
      case (req_payload.command)
         CMD_RECT:   start_step = ST_RECT_W;
         CMD_MATRIX: start_step = ST_HAS_SCALE;
         default:    start_step = ST_ADD_FLAG;
      endcase
   end

   // Status to the controller
   always_comb begin
      status.drop     = (step_ff == ST_IDLE) && (req_payload.command == CMD_NONE);
      status.done     = !field_done || (nstep == ST_IDLE) ||
                        ((nneed != 5'd0) && (bleft_cons == 4'd0));
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   // Next register values
   always_comb begin
      buf_in       = buf_ff;
      bleft_in     = bleft_ff;
      acc_in       = acc_ff;
      need_in      = need_ff;
      width_in     = width_ff;
      pres_in      = pres_ff;
      fill_in      = fill_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // Load a byte; open a record when none is in progress
      if (cmd.load && !status.drop) begin
         buf_in   = req_payload.data_byte;
         bleft_in = 4'd8;
         if (step_ff == ST_IDLE) begin
            pres_in  = 2'd0;
            width_in = 5'd0;
            fill_in  = 1'b0;
            step_in  = start_step;
            need_in  = step_need(start_step, 5'd0);
            acc_in   = 32'd0;
         end
      end

      // Drop a taken result
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Advance over the byte
      if (cmd.run) begin
         buf_in   = buf_cons;
         bleft_in = bleft_cons;
         if (!field_done) begin
            acc_in  = acc_cons;
            need_in = need_cons;
         end else begin
            step_in  = nstep;
            width_in = nwidth;
            pres_in  = npres;
            fill_in  = nfill;
            need_in  = nneed;
            acc_in   = 32'd0;
            if (emit) begin
               rsp_valid_in       = 1'b1;
               rsp_in.field_code  = ecode;
               rsp_in.value       = eval;
               rsp_in.record_last = elast;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bleft_ff     <= 4'd0;
         acc_ff       <= 32'd0;
         need_ff      <= 5'd0;
         width_ff     <= 5'd0;
         pres_ff      <= 2'd0;
         fill_ff      <= 1'b0;
         step_ff      <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         bleft_ff     <= bleft_in;
         acc_ff       <= acc_in;
         need_ff      <= need_in;
         width_ff     <= width_in;
         pres_ff      <= pres_in;
         fill_ff      <= fill_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/sbrd_checker.sv
// Port-level checks for the record decoder, bound to the top level.
// Depends on sbrd_pkg and swf_bit_record_decoder_unit.
`default_nettype none

module sbrd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input sbrd_pkg::rsp_payload_type rsp_payload
);
   import sbrd_pkg::*;

   logic       xfer;
   logic       have_ff;
   logic       prev_last_ff;
   logic [4:0] prev_code_ff;

   assign xfer = rsp_valid && !rsp_stall;

   // Track the previous result transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         prev_last_ff <= 1'b0;
         prev_code_ff <= 5'd0;
      end else if (xfer) begin
         have_ff      <= 1'b1;
         prev_last_ff <= rsp_payload.record_last;
         prev_code_ff <= rsp_payload.field_code;
      end
   end

   // Fields within a record arrive in order, none skipped
   a_code_order: assert property (@(posedge clock) disable iff (reset)
      xfer && have_ff && !prev_last_ff |->
         rsp_payload.field_code == prev_code_ff + 5'd1)
      else $error("field code out of record order");

   // A record opens with its first field
   a_record_open: assert property (@(posedge clock) disable iff (reset)
      xfer && (!have_ff || prev_last_ff) |->
         rsp_payload.field_code == FC_RECT_XMIN ||
         rsp_payload.field_code == FC_SCALE_X ||
         rsp_payload.field_code == FC_MULT_R)
      else $error("record does not open with its first field");

   // Last flag only on the final field of a kind
   a_record_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.record_last |->
         rsp_payload.field_code == FC_RECT_YMAX ||
         rsp_payload.field_code == FC_TRANS_Y ||
         rsp_payload.field_code == FC_ADD_A)
      else $error("record_last on a non-final field");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

endmodule

bind swf_bit_record_decoder_unit sbrd_checker u_sbrd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

>>> dv/tb_swf_bit_record_decoder_unit.sv
// Self-checking testbench for swf_bit_record_decoder_unit: byte stream in, decoded fields out.
// Depends on sbrd_pkg and the RTL. Directed rows come first, then randomly built records.
// A local model predicts fields except on typed rows, and random stalls fall on both channels.
`timescale 1ns / 1ps

module tb_swf_bit_record_decoder_unit;
   import sbrd_pkg::*;

   localparam int ITEM_TARGET  = 430;
   localparam int QUIET_ITEMS  = 50;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int NUM_DIRECTED = 22;
   localparam int NUM_TYPED    = 26;

   // One directed stream byte; when typed is set, n fields are read from typed_fields
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] cmd;
      logic       typed;
      logic [3:0] n;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      {8'hFF, CMD_NONE,   1'b1, 4'd0},   // undefined kind at record start: dropped
      {8'h07, CMD_RECT,   1'b1, 4'd4},   // zero width rect, trailing bits dropped
      {8'h0D, CMD_RECT,   1'b1, 4'd3},   // one-bit rect values
      {8'hFF, CMD_NONE,   1'b1, 4'd1},   // kind ignored mid-record
      {8'h01, CMD_MATRIX, 1'b1, 4'd6},   // no scale, no rotate, zero width translate
      {8'h03, CMD_CXFORM, 1'b1, 4'd8},   // no colour terms at all
      {8'h80, CMD_CXFORM, 1'b0, 4'd0},   // add terms of width zero
      {8'hFD, CMD_MATRIX, 1'b0, 4'd0},   // full-width scale pair at both extremes
      {8'hFF, CMD_RECT,   1'b0, 4'd0},
      {8'hFF, CMD_CXFORM, 1'b0, 4'd0},
      {8'hFF, CMD_NONE,   1'b0, 4'd0},
      {8'hFC, CMD_MATRIX, 1'b0, 4'd0},
      {8'h00, CMD_RECT,   1'b0, 4'd0},
      {8'h00, CMD_NONE,   1'b0, 4'd0},
      {8'h00, CMD_CXFORM, 1'b0, 4'd0},
      {8'h08, CMD_MATRIX, 1'b0, 4'd0},
      {8'h03, CMD_RECT,   1'b0, 4'd0},
      {8'h7F, CMD_NONE,   1'b0, 4'd0},
      {8'hC6, CMD_CXFORM, 1'b0, 4'd0},   // both colour flags, one-bit terms
      {8'h9F, CMD_MATRIX, 1'b0, 4'd0},
      {8'h00, CMD_RECT,   1'b1, 4'd4},   // all-zero byte
      {8'hFF, CMD_RECT,   1'b0, 4'd0}    // full-width rect left open for the random part
   };

   localparam rsp_payload_type TYPED_FIELDS [NUM_TYPED] = '{
      {FC_RECT_XMIN, 32'h0000_0000, 1'b0}, {FC_RECT_XMAX, 32'h0000_0000, 1'b0},
      {FC_RECT_YMIN, 32'h0000_0000, 1'b0}, {FC_RECT_YMAX, 32'h0000_0000, 1'b1},
      {FC_RECT_XMIN, 32'hFFFF_FFFF, 1'b0}, {FC_RECT_XMAX, 32'h0000_0000, 1'b0},
      {FC_RECT_YMIN, 32'hFFFF_FFFF, 1'b0},
      {FC_RECT_YMAX, 32'hFFFF_FFFF, 1'b1},
      {FC_SCALE_X,   SCALE_ONE,     1'b0}, {FC_SCALE_Y,   SCALE_ONE,     1'b0},
      {FC_ROT0,      32'h0000_0000, 1'b0}, {FC_ROT1,      32'h0000_0000, 1'b0},
      {FC_TRANS_X,   32'h0000_0000, 1'b0}, {FC_TRANS_Y,   32'h0000_0000, 1'b1},
      {FC_MULT_R,    32'h0000_0000, 1'b0}, {FC_MULT_G,    32'h0000_0000, 1'b0},
      {FC_MULT_B,    32'h0000_0000, 1'b0}, {FC_MULT_A,    32'h0000_0000, 1'b0},
      {FC_ADD_R,     32'h0000_0000, 1'b0}, {FC_ADD_G,     32'h0000_0000, 1'b0},
      {FC_ADD_B,     32'h0000_0000, 1'b0}, {FC_ADD_A,     32'h0000_0000, 1'b1},
      {FC_RECT_XMIN, 32'h0000_0000, 1'b0}, {FC_RECT_XMAX, 32'h0000_0000, 1'b0},
      {FC_RECT_YMIN, 32'h0000_0000, 1'b0}, {FC_RECT_YMAX, 32'h0000_0000, 1'b1}
   };

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   // Decoder model state
   logic [7:0]  shift_byte;
   int          shift_count;
   logic [31:0] field_acc;
   int          field_need;
   logic [4:0]  width_reg;
   step_type    dec_step;
   logic [1:0]  term_flags;   // bit 1 add terms, bit 0 mult terms

   rsp_payload_type decoded_fields [$];
   rsp_payload_type pending_fields [$];
   bit              record_bits [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int typed_pos = 0;
   int stall_left = 0;
   bit quiet = 1'b0;

   swf_bit_record_decoder_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- decoder model

   function automatic void emit_field(field_code_type code, logic [31:0] val, logic last);
      rsp_payload_type f;
      f.field_code  = code;
      f.value       = val;
      f.record_last = last;
      decoded_fields.push_back(f);
   endfunction

   function automatic logic [31:0] sign_extend(logic [31:0] raw);
      logic [31:0] r;
      r = raw;
      if (width_reg != 0 && raw[width_reg - 1]) r = raw | (32'hFFFF_FFFF << width_reg);
      return r;
   endfunction

   function automatic void open_step(step_type s);
      case (s)
         ST_RECT_W, ST_SCALE_W, ST_ROT_W, ST_TRANS_W: field_need = int'(WIDTH_FIELD_BITS);
         ST_CX_W: field_need = int'(CX_WIDTH_BITS);
         ST_HAS_SCALE, ST_HAS_ROT, ST_ADD_FLAG, ST_MULT_FLAG: field_need = int'(FLAG_BITS);
         default: field_need = int'(width_reg);
      endcase
      dec_step  = s;
      field_acc = '0;
   endfunction

   function automatic void close_record();
      dec_step    = ST_IDLE;
      field_need  = 0;
      field_acc   = '0;
      shift_count = 0;
      shift_byte  = '0;
   endfunction

   // Absent add terms still come out as four zeros
   function automatic void add_terms_stage();
      int i;
      if (term_flags[1]) begin
         open_step(ST_ADD_R);
      end else begin
         for (i = 0; i < 4; i++) emit_field(field_code_type'(FC_ADD_R + i), '0, i == 3);
         close_record();
      end
   endfunction

   function automatic void finish_field();
      logic [31:0] raw;
      step_type    s;
      int          i;
      raw = field_acc;
      s   = dec_step;
      case (s)
         ST_RECT_W, ST_SCALE_W, ST_ROT_W, ST_TRANS_W: begin
            width_reg = raw[4:0];
            open_step(step_type'(s + 5'd1));
         end
         ST_RECT_V0, ST_RECT_V1, ST_RECT_V2, ST_RECT_V3: begin
            emit_field(field_code_type'(FC_RECT_XMIN + (s - ST_RECT_V0)), sign_extend(raw),
                       s == ST_RECT_V3);
            if (s == ST_RECT_V3) close_record();
            else open_step(step_type'(s + 5'd1));
         end
         ST_HAS_SCALE: begin
            if (raw[0]) begin
               open_step(ST_SCALE_W);
            end else begin
               emit_field(FC_SCALE_X, SCALE_ONE, 1'b0);
               emit_field(FC_SCALE_Y, SCALE_ONE, 1'b0);
               open_step(ST_HAS_ROT);
            end
         end
         ST_SCALE_V0, ST_SCALE_V1: begin
            emit_field(field_code_type'(FC_SCALE_X + (s - ST_SCALE_V0)), sign_extend(raw), 1'b0);
            open_step(step_type'(s + 5'd1));
         end
         ST_HAS_ROT: begin
            if (raw[0]) begin
               open_step(ST_ROT_W);
            end else begin
               emit_field(FC_ROT0, '0, 1'b0);
               emit_field(FC_ROT1, '0, 1'b0);
               open_step(ST_TRANS_W);
            end
         end
         ST_ROT_V0, ST_ROT_V1: begin
            emit_field(field_code_type'(FC_ROT0 + (s - ST_ROT_V0)), sign_extend(raw), 1'b0);
            open_step(step_type'(s + 5'd1));
         end
         ST_TRANS_V0, ST_TRANS_V1: begin
            emit_field(field_code_type'(FC_TRANS_X + (s - ST_TRANS_V0)), sign_extend(raw),
                       s == ST_TRANS_V1);
            if (s == ST_TRANS_V1) close_record();
            else open_step(ST_TRANS_V1);
         end
         ST_ADD_FLAG: begin
            term_flags[1] = raw[0];
            open_step(ST_MULT_FLAG);
         end
         ST_MULT_FLAG: begin
            term_flags[0] = raw[0];
            open_step(ST_CX_W);
         end
         ST_CX_W: begin
            width_reg = {1'b0, raw[3:0]};
            if (term_flags[0]) begin
               open_step(ST_MULT_R);
            end else begin
               for (i = 0; i < 4; i++) emit_field(field_code_type'(FC_MULT_R + i), '0, 1'b0);
               add_terms_stage();
            end
         end
         ST_MULT_R, ST_MULT_G, ST_MULT_B, ST_MULT_A: begin
            emit_field(field_code_type'(FC_MULT_R + (s - ST_MULT_R)), sign_extend(raw), 1'b0);
            if (s == ST_MULT_A) add_terms_stage();
            else open_step(step_type'(s + 5'd1));
         end
         ST_ADD_R, ST_ADD_G, ST_ADD_B, ST_ADD_A: begin
            emit_field(field_code_type'(FC_ADD_R + (s - ST_ADD_R)), sign_extend(raw),
                       s == ST_ADD_A);
            if (s == ST_ADD_A) close_record();
            else open_step(step_type'(s + 5'd1));
         end
         default: close_record();
      endcase
   endfunction

   // Decode one byte into decoded_fields; return 1 when the byte is dropped
   function automatic bit decode_byte(logic [7:0] data, logic [1:0] cmd);
      bit busy;
      decoded_fields.delete();
      if (dec_step == ST_IDLE) begin
         if (cmd == CMD_NONE) return 1'b1;
         term_flags = '0;
         width_reg  = '0;
         if (cmd == CMD_RECT) open_step(ST_RECT_W);
         else if (cmd == CMD_MATRIX) open_step(ST_HAS_SCALE);
         else open_step(ST_ADD_FLAG);
      end
      shift_byte  = data;
      shift_count = 8;
      busy = 1'b1;
      while (busy) begin
         if (field_need == 0) begin
            finish_field();
            if (dec_step == ST_IDLE) busy = 1'b0;
         end else if (shift_count == 0) begin
            busy = 1'b0;
         end else begin
            field_acc  = {field_acc[30:0], shift_byte[7]};
            shift_byte = shift_byte << 1;
            shift_count--;
            field_need--;
         end
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // Drive one byte from a falling edge, hold it until the transfer, then return at a
   // falling edge; typed_n below zero takes the fields from the model
   task automatic send_byte(logic [7:0] data, logic [1:0] cmd, int typed_n);
      int i;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = {data, cmd};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!decode_byte(data, cmd)) items_sent++;
      if (typed_n < 0) begin
         foreach (decoded_fields[i]) pending_fields.push_back(decoded_fields[i]);
      end else begin
         for (i = 0; i < typed_n; i++) pending_fields.push_back(TYPED_FIELDS[typed_pos + i]);
         typed_pos += typed_n;
      end
      @(negedge clock);
   endtask

   function automatic void put_bits(int n, logic [31:0] v);
      int i;
      for (i = n - 1; i >= 0; i--) record_bits.push_back(v[i]);
   endfunction

   // Mostly narrow fields, so records stay short and hit every path
   function automatic int pick_width(int top);
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(0, 4);
      if (r < 9) return $urandom_range(0, top);
      return top;
   endfunction

   function automatic logic [31:0] pick_value(int w);
      if (w == 0) return '0;
      case ($urandom_range(0, 4))
         0: return 32'hFFFF_FFFF;
         1: return 32'd1 << (w - 1);
         2: return (32'd1 << (w - 1)) - 32'd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic void put_values(int count, int w);
      int i;
      for (i = 0; i < count; i++) put_bits(w, pick_value(w));
   endfunction

   // Build one well-formed record with random content and send it byte by byte
   task automatic send_record();
      logic [1:0] kind;
      logic [7:0] data;
      bit         has_a, has_b;
      int         w, k, j;
      kind = 2'($urandom_range(0, 2));
      record_bits.delete();
      case (kind)
         CMD_RECT: begin
            w = pick_width(31);
            put_bits(5, w);
            put_values(4, w);
         end
         CMD_MATRIX: begin
            for (k = 0; k < 2; k++) begin
               has_a = 1'($urandom_range(0, 1));
               put_bits(1, 32'(has_a));
               if (has_a) begin
                  w = pick_width(31);
                  put_bits(5, w);
                  put_values(2, w);
               end
            end
            w = pick_width(31);
            put_bits(5, w);
            put_values(2, w);
         end
         default: begin
            has_a = 1'($urandom_range(0, 1));
            has_b = 1'($urandom_range(0, 1));
            put_bits(1, 32'(has_a));
            put_bits(1, 32'(has_b));
            w = pick_width(15);
            put_bits(4, w);
            if (has_b) put_values(4, w);
            if (has_a) put_values(4, w);
         end
      endcase
      while (record_bits.size() % 8 != 0) record_bits.push_back(1'($urandom_range(0, 1)));
      for (k = 0; k < record_bits.size() / 8; k++) begin
         data = '0;
         for (j = 0; j < 8; j++) data = {data[6:0], record_bits[k * 8 + j]};
         send_byte(data, (k == 0) ? kind : 2'($urandom_range(0, 3)), -1);
      end
   endtask

   initial begin
      int r;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Walk the directed table
      for (r = 0; r < NUM_DIRECTED; r++) begin
         send_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].cmd,
                   DIRECTED_ROWS[r].typed ? int'(DIRECTED_ROWS[r].n) : -1);
      end

      // Random records, with some noise between them
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= ITEM_TARGET - QUIET_ITEMS) quiet = 1'b1;
         while (dec_step != ST_IDLE) send_byte(8'($urandom), 2'($urandom_range(0, 3)), -1);
         r = $urandom_range(0, 19);
         if (r < 2) send_byte(8'($urandom), CMD_NONE, -1);
         else if (r < 4) send_byte(8'($urandom), 2'($urandom_range(0, 2)), -1);
         else send_record();
      end
      req_valid = 1'b0;

      // Drain, then allow the block to settle
      while (pending_fields.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_fields.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Hold off results in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else if (!quiet && !reset && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_stall  = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // ---------------------------------------------------------------- checking

   // Compare each result transfer with the oldest expected field
   always @(posedge clock) begin : check_fields
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_fields.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected field: code %0d value %0d last %0b",
                        rsp_payload.field_code, $signed(rsp_payload.value),
                        rsp_payload.record_last);
         end else begin
            want = pending_fields.pop_front();
            if (want.field_code !== rsp_payload.field_code || want.value !== rsp_payload.value ||
                want.record_last !== rsp_payload.record_last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp code %0d value %0d last %0b, got %0d %0d %0b",
                           want.field_code, $signed(want.value), want.record_last,
                           rsp_payload.field_code, $signed(rsp_payload.value),
                           rsp_payload.record_last);
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

endmodule
